### rtl/kda_pkg.sv
`default_nettype none

package kda_pkg;

    // Field widths of the scan and result items.
    localparam int MASK_W  = 16;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 3;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [TIME_W-1:0]  tick_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;
    typedef logic [INDEX_W-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_DEBOUNCE_TIME   = 3'd0;
    localparam cfg_index_t REG_REPEAT_DELAY    = 3'd1;
    localparam cfg_index_t REG_REPEAT_INTERVAL = 3'd2;
    localparam cfg_index_t REG_CHANGE_HOLDOFF  = 3'd3;
    localparam cfg_index_t REG_REPEAT_KEY_MASK = 3'd4;

    // Configuration reset values.
    localparam tick_t RST_DEBOUNCE_TIME   = 16'd10;
    localparam tick_t RST_REPEAT_DELAY    = 16'd500;
    localparam tick_t RST_REPEAT_INTERVAL = 16'd25;
    localparam tick_t RST_CHANGE_HOLDOFF  = 16'd5;
    localparam mask_t RST_REPEAT_KEY_MASK = 16'd0;

endpackage

`default_nettype wire

### rtl/key_debounce_autorepeat.sv
`default_nettype none

// Channel  Handshake                 Payload
// -------  ------------------------  ------------------------------------
// scan in  in_valid / in_stall       key_mask, now_time
// event    out_valid / out_stall     send_mask, held_mask
// config   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A scan request is registered, evaluated combinationally against the debounce
// state, and any event lands in the output register; one scan per cycle is
// sustained while events are taken.
// Reset clears the configuration to its defaults and all key state to zero.
// A stall on the event side holds the output register and, once the
// registered scan cannot move on, raises in_stall. cfg_ready is always high.
module key_debounce_autorepeat (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire kda_pkg::mask_t   key_mask,
    input  wire kda_pkg::tick_t   now_time,
    output logic                  out_valid,
    input  wire                   out_stall,
    output kda_pkg::mask_t        send_mask,
    output kda_pkg::mask_t        held_mask,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire kda_pkg::cfg_index_t cfg_index,
    input  wire kda_pkg::cfg_data_t  cfg_data
);
    import kda_pkg::*;

    // Configuration registers.
    tick_t debounce_time_reg;
    tick_t repeat_delay_reg;
    tick_t repeat_interval_reg;
    tick_t change_holdoff_reg;
    mask_t repeat_key_mask_reg;

    // Input register.
    logic  scan_valid_reg;
    mask_t scan_mask_reg;
    tick_t scan_time_reg;

    // Debounce and repeat state.
    mask_t candidate_mask_reg, candidate_mask_next;
    tick_t settle_start_reg, settle_start_next;
    mask_t accepted_mask_reg, accepted_mask_next;
    tick_t last_event_time_reg, last_event_time_next;
    logic  repeating_reg, repeating_next;

    // Output register.
    logic  out_valid_reg;
    mask_t send_mask_reg;
    mask_t held_mask_reg;

    logic  advance;
    logic  fire;
    mask_t send;
    tick_t settle_elapsed;
    tick_t since;

    assign cfg_ready = 1'b1;

    // The registered scan moves on when the output register is free or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = scan_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign send_mask = send_mask_reg;
    assign held_mask = held_mask_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg   <= RST_DEBOUNCE_TIME;
            repeat_delay_reg    <= RST_REPEAT_DELAY;
            repeat_interval_reg <= RST_REPEAT_INTERVAL;
            change_holdoff_reg  <= RST_CHANGE_HOLDOFF;
            repeat_key_mask_reg <= RST_REPEAT_KEY_MASK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_data;
                REG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_data;
                REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                REG_CHANGE_HOLDOFF:  change_holdoff_reg  <= cfg_data;
                REG_REPEAT_KEY_MASK: repeat_key_mask_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Evaluate the registered scan against the current state.
    always_comb
    begin
        candidate_mask_next  = candidate_mask_reg;
        settle_start_next    = settle_start_reg;
        accepted_mask_next   = accepted_mask_reg;
        last_event_time_next = last_event_time_reg;
        repeating_next       = repeating_reg;
        fire                 = 1'b0;

        settle_elapsed = scan_time_reg - settle_start_reg;
        since          = scan_time_reg - last_event_time_reg;
        send = (scan_mask_reg ^ accepted_mask_reg) | (scan_mask_reg & repeat_key_mask_reg);

        if (scan_mask_reg != candidate_mask_reg)
        begin
            // A new mask restarts the settle timer.
            candidate_mask_next = scan_mask_reg;
            settle_start_next   = scan_time_reg;
        end
        else if (settle_elapsed >= debounce_time_reg)
        begin
            if (scan_mask_reg == accepted_mask_reg)
            begin
                if (repeating_reg)
                begin
                    fire = (since > repeat_interval_reg) && (send != '0);
                end
                else
                begin
                    fire = (since > repeat_delay_reg) && (send != '0);
                    if (fire)
                    begin
                        repeating_next = 1'b1;
                    end
                end
            end
            else
            begin
                fire = (since > change_holdoff_reg) && (send != '0);
                if (fire)
                begin
                    repeating_next = 1'b0;
                end
            end

            if (fire)
            begin
                last_event_time_next = scan_time_reg;
                accepted_mask_next   = scan_mask_reg;
            end
        end
    end

    // Control and key state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
            candidate_mask_reg  <= '0;
            settle_start_reg    <= '0;
            accepted_mask_reg   <= '0;
            last_event_time_reg <= '0;
            repeating_reg       <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                scan_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= scan_valid_reg && fire;
            end
            if (scan_valid_reg && advance)
            begin
                candidate_mask_reg  <= candidate_mask_next;
                settle_start_reg    <= settle_start_next;
                accepted_mask_reg   <= accepted_mask_next;
                last_event_time_reg <= last_event_time_next;
                repeating_reg       <= repeating_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            scan_mask_reg <= key_mask;
            scan_time_reg <= now_time;
        end
        if (scan_valid_reg && advance && fire)
        begin
            send_mask_reg <= send;
            held_mask_reg <= scan_mask_reg;
        end
    end

endmodule

`default_nettype wire

### bench/kda_event_checker.sv
import kda_pkg::*;

module kda_event_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_stall,
    input  mask_t      key_mask,
    input  tick_t      now_time,
    input  wire        out_valid,
    input  wire        out_stall,
    input  mask_t      send_mask,
    input  mask_t      held_mask,
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,
    output int         fail_count,
    output int         pending_events
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        mask_t send;
        mask_t held;
    } key_event_t;

    // Events predicted from accepted scans, oldest first.
    key_event_t expected_events[$];
    int         errors;

    // Shadow copy of the configuration registers.
    tick_t debounce_ticks;
    tick_t first_repeat_ticks;
    tick_t repeat_ticks;
    tick_t holdoff_ticks;
    mask_t always_send_keys;

    // Shadow copy of the debounce and repeat state.
    mask_t scan_candidate;
    tick_t candidate_since;
    mask_t debounced_keys;
    tick_t last_fire_time;
    logic  auto_repeat_on;

    // Apply one configuration request; unused indexes are dropped.
    task automatic write_register(input cfg_index_t idx, input cfg_data_t value);
        case (idx)
            REG_DEBOUNCE_TIME:   debounce_ticks     = value;
            REG_REPEAT_DELAY:    first_repeat_ticks = value;
            REG_REPEAT_INTERVAL: repeat_ticks       = value;
            REG_CHANGE_HOLDOFF:  holdoff_ticks      = value;
            REG_REPEAT_KEY_MASK: always_send_keys   = value;
            default: ;
        endcase
    endtask

    // Run one scan through the debounce logic and queue any event it fires.
    task automatic predict_scan(input mask_t scan, input tick_t stamp);
        tick_t      settled_for;
        tick_t      since_fire;
        mask_t      to_send;
        logic       fire;
        key_event_t ev;
        fire = 1'b0;
        if (scan != scan_candidate)
        begin
            // A new mask restarts the settling window.
            scan_candidate  = scan;
            candidate_since = stamp;
        end
        else
        begin
            settled_for = stamp - candidate_since;
            if (settled_for >= debounce_ticks)
            begin
                to_send    = (scan ^ debounced_keys) | (scan & always_send_keys);
                since_fire = stamp - last_fire_time;
                if (scan == debounced_keys)
                begin
                    // Held mask: first repeat after the delay, then at the interval.
                    if (auto_repeat_on)
                    begin
                        if (since_fire > repeat_ticks)
                            fire = (to_send != '0);
                    end
                    else if (since_fire > first_repeat_ticks)
                    begin
                        fire = (to_send != '0);
                        if (fire)
                            auto_repeat_on = 1'b1;
                    end
                end
                else if (since_fire > holdoff_ticks)
                begin
                    // Changed mask is reported once the hold-off has passed.
                    fire = (to_send != '0);
                    if (fire)
                        auto_repeat_on = 1'b0;
                end
                if (fire)
                begin
                    last_fire_time = stamp;
                    debounced_keys = scan;
                    ev.send = to_send;
                    ev.held = scan;
                    expected_events.push_back(ev);
                end
            end
        end
    endtask

    // Compare one accepted event against the oldest prediction.
    task automatic check_event(input mask_t got_send, input mask_t got_held);
        key_event_t want;
        if (expected_events.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected event, expected none, got send_mask=%h held_mask=%h",
                     $time, got_send, got_held);
        end
        else
        begin
            want = expected_events.pop_front();
            if (want.send != got_send)
            begin
                errors++;
                $display("%0t: send_mask mismatch, expected %h, got %h",
                         $time, want.send, got_send);
            end
            if (want.held != got_held)
            begin
                errors++;
                $display("%0t: held_mask mismatch, expected %h, got %h",
                         $time, want.held, got_held);
            end
        end
    endtask

    // Watch all three channels at each edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks     = RST_DEBOUNCE_TIME;
            first_repeat_ticks = RST_REPEAT_DELAY;
            repeat_ticks       = RST_REPEAT_INTERVAL;
            holdoff_ticks      = RST_CHANGE_HOLDOFF;
            always_send_keys   = RST_REPEAT_KEY_MASK;
            scan_candidate     = '0;
            candidate_since    = '0;
            debounced_keys     = '0;
            last_fire_time     = '0;
            auto_repeat_on     = 1'b0;
            expected_events.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_event(send_mask, held_mask);
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                predict_scan(key_mask, now_time);
        end
        pending_events <= expected_events.size();
        fail_count     <= errors;
    end

    initial
    begin
        errors         = 0;
        fail_count     = 0;
        pending_events = 0;
    end

endmodule

### bench/tb_key_debounce_autorepeat.sv
import kda_pkg::*;

module tb_key_debounce_autorepeat;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DRAIN_CYCLES     = 8;
    localparam int         RUN_LIMIT_NS     = 400_000;
    localparam int         PHASE_ITEMS      = 200;
    localparam int         RANDOM_PHASES    = 8;
    localparam cfg_index_t FIRST_UNUSED_REG = REG_REPEAT_KEY_MASK + 3'd1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    mask_t      key_mask  = '0;
    tick_t      now_time  = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    cfg_index_t cfg_index = '0;
    cfg_data_t  cfg_data  = '0;

    logic  in_stall;
    logic  out_valid;
    mask_t send_mask;
    mask_t held_mask;
    logic  cfg_ready;
    int    fail_count;
    int    pending_events;

    // Running tick counter and burst flags for each side.
    tick_t stamp;
    mask_t last_mask;
    logic  scan_burst  = 1'b0;
    logic  event_burst = 1'b0;

    key_debounce_autorepeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_mask  (key_mask),
        .now_time  (now_time),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .send_mask (send_mask),
        .held_mask (held_mask),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kda_event_checker event_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_mask       (key_mask),
        .now_time       (now_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_mask      (send_mask),
        .held_mask      (held_mask),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_events (pending_events)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Event side: stall a random number of cycles before taking each event.
    initial
    begin
        int gap;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                event_burst = !event_burst;
            gap = event_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Present one scan request after a random gap and hold it until taken.
    task automatic send_scan(input mask_t scan, input tick_t tick);
        int gap;
        gap = scan_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_mask <= scan;
        now_time <= tick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until every predicted event has arrived, then let the pipeline drain.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_events != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One configuration request, held until taken.
    task automatic put_reg(input cfg_index_t idx, input cfg_data_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Rewrite every register while idle, plus one write to an unused index.
    task automatic write_config(input tick_t deb, input tick_t dly, input tick_t ivl,
                                input tick_t hold, input mask_t rkm);
        in_valid <= 1'b0;
        wait_idle();
        put_reg(FIRST_UNUSED_REG + cfg_index_t'($urandom_range(0, 2)), cfg_data_t'($urandom));
        put_reg(REG_DEBOUNCE_TIME, deb);
        put_reg(REG_REPEAT_DELAY, dly);
        put_reg(REG_REPEAT_INTERVAL, ivl);
        put_reg(REG_CHANGE_HOLDOFF, hold);
        put_reg(REG_REPEAT_KEY_MASK, rkm);
        cfg_valid <= 1'b0;
    endtask

    // Next key mask: cleared, one bit of the last one flipped, a single bit, random, or unchanged.
    function automatic mask_t pick_mask(input mask_t prev);
        case ($urandom_range(0, 4))
            0:       pick_mask = '0;
            1:       pick_mask = prev ^ (mask_t'(1) << $urandom_range(0, 15));
            2:       pick_mask = mask_t'(1) << $urandom_range(0, 15);
            3:       pick_mask = mask_t'($urandom);
            default: pick_mask = prev;
        endcase
    endfunction

    // Mostly held masks with advancing time, mixed with stray scans.
    task automatic run_random_phase(input int n_items, input int step_max);
        int sent;
        int hold;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 6) == 0)
                scan_burst = !scan_burst;
            if ($urandom_range(0, 4) == 0)
            begin
                stamp = tick_t'($urandom);
                send_scan(mask_t'($urandom), stamp);
                sent++;
            end
            else
            begin
                last_mask = pick_mask(last_mask);
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45)
                                                   : $urandom_range(1, 16);
                repeat (hold)
                begin
                    if ($urandom_range(0, 39) == 0)
                        stamp = stamp + tick_t'($urandom);
                    else
                        stamp = stamp + tick_t'($urandom_range(0, step_max));
                    send_scan(last_mask, stamp);
                    sent++;
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        stamp     = '0;
        last_mask = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: settle, change, empty repeat, release, wrap.
        send_scan(16'h0001, 16'd0);
        send_scan(16'h0001, 16'd5);
        send_scan(16'h0001, 16'd10);
        send_scan(16'h0001, 16'd600);
        send_scan(16'h0000, 16'd601);
        send_scan(16'h0000, 16'd620);
        send_scan(16'hFFFF, 16'd621);
        send_scan(16'hFFFF, 16'hFFFF);

        // All-zero timing with every key repeating.
        write_config(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_scan(16'hFFFF, 16'd100);
        send_scan(16'hFFFF, 16'd100);
        send_scan(16'hFFFF, 16'd101);
        send_scan(16'h8000, 16'd102);
        send_scan(16'h8000, 16'd102);
        send_scan(16'h8000, 16'd103);

        // Maximum timing: settles only at the full window, hold-off never passes.
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0F0F);
        send_scan(16'h1234, 16'd0);
        send_scan(16'h1234, 16'hFFFE);
        send_scan(16'h1234, 16'hFFFF);
        send_scan(16'h1234, 16'h0000);

        // Random phases under varied settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                write_config(RST_DEBOUNCE_TIME, RST_REPEAT_DELAY, RST_REPEAT_INTERVAL,
                             RST_CHANGE_HOLDOFF, mask_t'($urandom));
            else if (phase == 1)
                write_config(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
            else
                write_config(tick_t'($urandom_range(0, 20)), tick_t'($urandom_range(0, 150)),
                             tick_t'($urandom_range(0, 30)), tick_t'($urandom_range(0, 20)),
                             mask_t'($urandom));
            run_random_phase(PHASE_ITEMS, $urandom_range(4, 30));
        end

        in_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake or a missing event.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/kda_pkg.sv
rtl/key_debounce_autorepeat.sv
bench/kda_event_checker.sv
bench/tb_key_debounce_autorepeat.sv
